// ===== hw/rtl/salru_pkg.sv =====
// Shared types and constants for the set-associative LRU tag store.
// Used by the way unit, the top level and the checker; no dependencies of its own.
package salru_pkg;

  // payload and parameter defaults
  localparam int ADDR_BITS      = 64;
  localparam int DEF_SET_COUNT  = 256;
  localparam int DEF_WAYS       = 8;
  localparam int DEF_ADDR_WIDTH = 64;

  // configuration port
  localparam int CFG_BITS     = 4;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SET_BITS    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BLOCK_BITS  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WAYS_IN_USE = 2'd2;

  localparam logic [CFG_BITS-1:0] RST_SET_BITS    = 4'd6;
  localparam logic [CFG_BITS-1:0] RST_BLOCK_BITS  = 4'd6;
  localparam logic [CFG_BITS-1:0] RST_WAYS_IN_USE = 4'd8;

  // result status codes
  typedef enum logic [2:0] {
    ST_MISS      = 3'd0,
    ST_HIT       = 3'd1,
    ST_EVICT     = 3'd2,
    ST_FLUSHED   = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  // transaction opcodes
  typedef enum logic {
    OP_ACCESS = 1'b0,
    OP_FLUSH  = 1'b1
  } op_t;

  // recency update applied by the way unit
  typedef enum logic [1:0] {
    UPD_NONE,
    UPD_FLUSH,
    UPD_HIT,
    UPD_FILL
  } upd_mode_t;

  // per-way flags from the way unit
  typedef struct packed {
    logic match;
    logic empty;
    logic older;
  } probe_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD,
    S_SCAN,
    S_DECIDE,
    S_UPDATE,
    S_WRITE,
    S_DONE
  } seq_state_t;

endpackage

// ===== hw/rtl/salru_set_mem.sv =====
// One row per set: tags, ages and valid bits of all ways.
// Single write port, single registered read port. Uses no package items.
module salru_set_mem #(
  parameter int DEPTH = 256,
  parameter int ROW_W = 544,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  logic [ROW_W-1:0] wdata,
  input  logic             re,
  input  logic [IDX_W-1:0] raddr,
  output logic [ROW_W-1:0] rdata
);

  logic [ROW_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/salru_way_unit.sv =====
// Shared per-way unit: tag compare, age compare and recency update for one way.
// Depends on salru_pkg for the update mode and probe flag types.
module salru_way_unit #(
  parameter int AW   = 64,
  parameter int WAYS = 8,
  localparam int AGE_W = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  salru_pkg::upd_mode_t mode,
  input  logic [AW-1:0]        key_tag,
  input  logic                 way_valid,
  input  logic [AW-1:0]        way_tag,
  input  logic [AGE_W-1:0]     way_age,
  input  logic [AGE_W-1:0]     ref_age,
  input  logic                 is_sel,
  output salru_pkg::probe_t    probe,
  output logic [AGE_W-1:0]     new_age
);

  logic lt;
  logic gt;

  // the same age comparisons serve scan and update
  assign lt = way_age < ref_age;
  assign gt = way_age > ref_age;

  // lookup flags
  assign probe.match = way_valid && (way_tag == key_tag);
  assign probe.empty = !way_valid;
  assign probe.older = gt;

  // recency update
  always_comb begin
    new_age = way_age;
    case (mode)
      salru_pkg::UPD_FLUSH: begin
        if (way_valid && gt) new_age = way_age - AGE_W'(1);
      end
      salru_pkg::UPD_HIT: begin
        if (is_sel) begin
          new_age = '0;
        end else if (way_valid && lt) begin
          new_age = way_age + AGE_W'(1);
        end
      end
      salru_pkg::UPD_FILL: begin
        if (way_valid && lt) new_age = way_age + AGE_W'(1);
      end
      default: begin
        new_age = way_age;
      end
    endcase
  end

endmodule

// ===== hw/rtl/set_assoc_cache_lru_tags.sv =====
// Sequence: an accepted transaction passes load, scan, decide, update, write and done; the
// single way unit scans the first n ways (n = effective ways_in_use) once for lookup and once
// for the recency update. A flush that finds nothing goes from decide straight to done. One
// transaction at a time: no new one is taken until done has issued the result, and done waits
// while out_stall holds a pending result. Reset: synchronous; configuration registers return
// to 6/6/8, then a clearing pass zeroes tags, valid bits and ages of every set while in_stall stays high.
module set_assoc_cache_lru_tags_unit #(
  parameter int SET_COUNT  = salru_pkg::DEF_SET_COUNT,
  parameter int WAYS       = salru_pkg::DEF_WAYS,
  parameter int ADDR_WIDTH = salru_pkg::DEF_ADDR_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // request channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 op,
  input  logic [salru_pkg::ADDR_BITS-1:0]      addr,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [2:0]                           status,
  output logic [salru_pkg::ADDR_BITS-1:0]      fill_addr,
  output logic [salru_pkg::ADDR_BITS-1:0]      evict_addr,
  // configuration writes
  input  logic                                 cfg_wen,
  input  logic [salru_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [salru_pkg::CFG_BITS-1:0]       cfg_data
);

  localparam int AW      = ADDR_WIDTH;
  localparam int PORT_AW = salru_pkg::ADDR_BITS;
  localparam int CW      = salru_pkg::CFG_BITS;
  localparam int SIDX_W  = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam int MAX_SB  = $clog2(SET_COUNT + 1) - 1;
  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int NW      = $clog2(WAYS + 1);
  localparam int AGE_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ROW_W   = WAYS * (AW + AGE_W + 1);
  localparam logic [AGE_W-1:0] MAX_AGE = AGE_W'(WAYS - 1);

  // sequencer
  salru_pkg::seq_state_t state;
  salru_pkg::seq_state_t state_next;
  logic [SIDX_W-1:0]     clr_cnt;
  logic                  clr_last;

  // configuration registers
  logic [CW-1:0] set_bits;
  logic [CW-1:0] block_bits;
  logic [CW-1:0] ways_in_use;

  // transaction registers
  salru_pkg::op_t    op_q;
  logic [AW-1:0]     key_tag;
  logic [AW-1:0]     ins_blk;
  logic [SIDX_W-1:0] set_idx;
  logic [NW-1:0]     n_eff;
  logic [WAY_W-1:0]  way;
  logic              way_last;

  // working copy of the set row
  logic [WAYS-1:0][AW-1:0]    row_tag;
  logic [WAYS-1:0][AGE_W-1:0] row_age;
  logic [WAYS-1:0]            row_valid;

  // scan results
  logic             hit_found;
  logic [WAY_W-1:0] hit_way;
  logic             slot_found;
  logic [WAY_W-1:0] slot_way;
  logic [AGE_W-1:0] best_age;
  logic [WAY_W-1:0] best_way;

  // decision registers
  salru_pkg::upd_mode_t mode_q;
  logic [WAY_W-1:0]     sel_way;
  logic [AGE_W-1:0]     ref_age_q;
  salru_pkg::status_t   res_status;
  logic [AW-1:0]        res_vic;

  // decision logic
  salru_pkg::upd_mode_t dec_mode;
  logic [WAY_W-1:0]     dec_sel;
  salru_pkg::status_t   dec_status;
  logic [AGE_W-1:0]     dec_ref;

  // address split at accept
  logic [AW-1:0]     a_in;
  logic [AW-1:0]     a_ones;
  logic [AW-1:0]     a_shr;
  logic [CW-1:0]     sb_eff;
  logic [CW:0]       split_amt;
  logic [AW-1:0]     tag_c;
  logic [AW-1:0]     ins_c;
  logic [SIDX_W-1:0] sidx_ones;
  logic [SIDX_W-1:0] set_c;
  logic [NW-1:0]     n_c;
  logic              accept;
  logic              out_free;

  // memory and way unit hookup
  logic                       mem_we;
  logic                       mem_re;
  logic [SIDX_W-1:0]          mem_waddr;
  logic [ROW_W-1:0]           mem_wdata;
  logic [ROW_W-1:0]           mem_rdata;
  logic [WAYS-1:0]            wr_valid;
  logic [WAYS-1:0][AGE_W-1:0] wr_age;
  salru_pkg::upd_mode_t       u_mode;
  logic [AGE_W-1:0]           u_ref;
  salru_pkg::probe_t          u_probe;
  logic [AGE_W-1:0]           u_new_age;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign clr_last = clr_cnt == SIDX_W'(SET_COUNT - 1);
  assign way_last = (NW'(way) + NW'(1)) == n_eff;

  // split the incoming address by the current field widths
  always_comb begin
    a_in      = addr[AW-1:0];
    a_ones    = '1;
    sidx_ones = '1;
    sb_eff    = (set_bits > CW'(MAX_SB)) ? CW'(MAX_SB) : set_bits;
    split_amt = {1'b0, sb_eff} + {1'b0, block_bits};
    tag_c     = a_in & (a_ones << split_amt);
    ins_c     = a_in & (a_ones << block_bits);
    a_shr     = a_in >> block_bits;
    set_c     = a_shr[SIDX_W-1:0] & ~(sidx_ones << sb_eff);
    if (ways_in_use == '0) begin
      n_c = NW'(1);
    end else if ({1'b0, ways_in_use} > 5'(WAYS)) begin
      n_c = NW'(WAYS);
    end else begin
      n_c = NW'(ways_in_use);
    end
  end

  // choose the update once the scan is complete
  always_comb begin
    dec_mode   = salru_pkg::UPD_NONE;
    dec_sel    = hit_way;
    dec_status = salru_pkg::ST_NOT_FOUND;
    if (op_q == salru_pkg::OP_FLUSH) begin
      if (hit_found) begin
        dec_mode   = salru_pkg::UPD_FLUSH;
        dec_status = salru_pkg::ST_FLUSHED;
      end
    end else if (hit_found) begin
      dec_mode   = salru_pkg::UPD_HIT;
      dec_status = salru_pkg::ST_HIT;
    end else if (slot_found) begin
      dec_mode   = salru_pkg::UPD_FILL;
      dec_sel    = slot_way;
      dec_status = salru_pkg::ST_MISS;
    end else begin
      dec_mode   = salru_pkg::UPD_FILL;
      dec_sel    = best_way;
      dec_status = salru_pkg::ST_EVICT;
    end
    dec_ref = (dec_mode == salru_pkg::UPD_FILL) ? MAX_AGE : row_age[dec_sel];
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      salru_pkg::S_CLEAR:  if (clr_last) state_next = salru_pkg::S_IDLE;
      salru_pkg::S_IDLE:   if (in_valid) state_next = salru_pkg::S_LOAD;
      salru_pkg::S_LOAD:   state_next = salru_pkg::S_SCAN;
      salru_pkg::S_SCAN:   if (way_last) state_next = salru_pkg::S_DECIDE;
      salru_pkg::S_DECIDE: begin
        state_next = (dec_mode == salru_pkg::UPD_NONE) ? salru_pkg::S_DONE
                                                       : salru_pkg::S_UPDATE;
      end
      salru_pkg::S_UPDATE: if (way_last) state_next = salru_pkg::S_WRITE;
      salru_pkg::S_WRITE:  state_next = salru_pkg::S_DONE;
      salru_pkg::S_DONE:   if (out_free) state_next = salru_pkg::S_IDLE;
      default:             state_next = salru_pkg::S_CLEAR;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall  = state != salru_pkg::S_IDLE;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = set_idx;
    u_mode    = salru_pkg::UPD_NONE;
    u_ref     = best_age;
    case (state)
      salru_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
      end
      salru_pkg::S_IDLE: begin
        mem_re = in_valid;
      end
      salru_pkg::S_UPDATE: begin
        u_mode = mode_q;
        u_ref  = ref_age_q;
      end
      salru_pkg::S_WRITE: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  // row written back: a filled way becomes valid and most recent
  always_comb begin
    wr_valid = row_valid;
    wr_age   = row_age;
    if (mode_q == salru_pkg::UPD_FILL) begin
      wr_valid[sel_way] = 1'b1;
      wr_age[sel_way]   = '0;
    end
    mem_wdata = (state == salru_pkg::S_CLEAR) ? '0 : {row_tag, wr_age, wr_valid};
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= salru_pkg::S_CLEAR;
      clr_cnt     <= '0;
      out_valid   <= 1'b0;
      set_bits    <= salru_pkg::RST_SET_BITS;
      block_bits  <= salru_pkg::RST_BLOCK_BITS;
      ways_in_use <= salru_pkg::RST_WAYS_IN_USE;
    end else begin
      state <= state_next;
      if (state == salru_pkg::S_CLEAR) clr_cnt <= clr_cnt + SIDX_W'(1);
      if (state == salru_pkg::S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_wen) begin
        case (cfg_index)
          salru_pkg::CFG_SET_BITS:    set_bits    <= cfg_data;
          salru_pkg::CFG_BLOCK_BITS:  block_bits  <= cfg_data;
          salru_pkg::CFG_WAYS_IN_USE: ways_in_use <= cfg_data;
          default:                    set_bits    <= set_bits;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      salru_pkg::S_IDLE: begin
        if (accept) begin
          op_q    <= salru_pkg::op_t'(op);
          key_tag <= tag_c;
          ins_blk <= ins_c;
          set_idx <= set_c;
          n_eff   <= n_c;
        end
      end
      salru_pkg::S_LOAD: begin
        {row_tag, row_age, row_valid} <= mem_rdata;
        hit_found  <= 1'b0;
        hit_way    <= '0;
        slot_found <= 1'b0;
        slot_way   <= '0;
        best_age   <= '0;
        best_way   <= '0;
        way        <= '0;
      end
      salru_pkg::S_SCAN: begin
        if (u_probe.match && !hit_found) begin
          hit_found <= 1'b1;
          hit_way   <= way;
        end
        if (u_probe.empty && !slot_found) begin
          slot_found <= 1'b1;
          slot_way   <= way;
        end
        if (u_probe.older) begin
          best_age <= row_age[way];
          best_way <= way;
        end
        way <= way + WAY_W'(1);
      end
      salru_pkg::S_DECIDE: begin
        mode_q     <= dec_mode;
        sel_way    <= dec_sel;
        ref_age_q  <= dec_ref;
        res_status <= dec_status;
        way        <= '0;
        res_vic    <= (dec_status == salru_pkg::ST_EVICT)
                      ? (row_tag[best_way] | (AW'(set_idx) << block_bits)) : '0;
        // flushed or evicted line drops out before the age update
        if (dec_mode == salru_pkg::UPD_FLUSH || dec_status == salru_pkg::ST_EVICT) begin
          row_valid[dec_sel] <= 1'b0;
        end
        if (dec_mode == salru_pkg::UPD_FILL) row_tag[dec_sel] <= key_tag;
      end
      salru_pkg::S_UPDATE: begin
        row_age[way] <= u_new_age;
        way          <= way + WAY_W'(1);
      end
      salru_pkg::S_DONE: begin
        if (out_free) begin
          status     <= res_status;
          fill_addr  <= PORT_AW'((mode_q == salru_pkg::UPD_FILL) ? ins_blk : '0);
          evict_addr <= PORT_AW'(res_vic);
        end
      end
      default: begin
        way <= way;
      end
    endcase
  end

  // shared way unit
  salru_way_unit #(
    .AW   (AW),
    .WAYS (WAYS)
  ) u_way (
    .mode      (u_mode),
    .key_tag   (key_tag),
    .way_valid (row_valid[way]),
    .way_tag   (row_tag[way]),
    .way_age   (row_age[way]),
    .ref_age   (u_ref),
    .is_sel    (way == sel_way),
    .probe     (u_probe),
    .new_age   (u_new_age)
  );

  // set row storage
  salru_set_mem #(
    .DEPTH (SET_COUNT),
    .ROW_W (ROW_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (set_c),
    .rdata (mem_rdata)
  );

endmodule

// ===== hw/rtl/salru_checker.sv =====
// Port-level checks for the LRU tag store, bound to the top level.
// Depends on salru_pkg for status codes and the port width.
module salru_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [2:0]                      status,
  input logic [salru_pkg::ADDR_BITS-1:0] fill_addr,
  input logic [salru_pkg::ADDR_BITS-1:0] evict_addr
);

  // one transaction at a time: stall right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while previous transaction in progress");

  // clearing pass holds off requests right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> in_stall)
    else $error("request channel open during clearing pass");

  // victim only reported on eviction
  a_victim_only_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != salru_pkg::ST_EVICT |-> evict_addr == '0)
    else $error("evict address without eviction");

  // nothing inserted on hit or flush
  a_insert_only_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == salru_pkg::ST_HIT || status == salru_pkg::ST_FLUSHED ||
                  status == salru_pkg::ST_NOT_FOUND) |-> fill_addr == '0)
    else $error("fill address reported without a fill");

  // stalled result holds its status and evict address
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(evict_addr))
    else $error("stalled result changed");

endmodule

bind set_assoc_cache_lru_tags_unit salru_checker u_salru_checker (.*);
